// ----- hw/rtl/smf_pkg.sv -----
// Shared types and constants for the SPI message framer.
// Holds the item and result structs, the configuration struct and register indexes.
// No dependencies.
`default_nettype none
package smf_pkg;

	// Request kinds carried by req_type.
	localparam logic REQ_START   = 1'b0;
	localparam logic REQ_PAYLOAD = 1'b1;

	// Marker byte that announces a two-byte length.
	localparam logic [7:0] EXT_LEN_MARK = 8'hFF;

	// Register indexes (byte address bits [3:2]).
	localparam int unsigned REG_ADDR_W = 4;
	localparam logic [1:0] REG_ENABLE    = 2'd0;
	localparam logic [1:0] REG_PIPE_BYTE = 2'd1;
	localparam logic [1:0] REG_MASTER    = 2'd2;

	// Largest number of bytes one item can produce, and the index width for it.
	localparam int unsigned BURST_MAX = 8;
	localparam int unsigned BURST_IDX_W = $clog2(BURST_MAX);

	typedef struct packed {
		logic        req_type;
		logic [7:0]  msg_id;
		logic [15:0] payload_length;
		logic [7:0]  payload_byte;
	} smf_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_last;
	} smf_out_t;

	typedef struct packed {
		logic       framer_enable;
		logic [7:0] control_pipe_byte;
		logic [7:0] master_address;
	} smf_cfg_t;

	// All result bytes caused by one item.
	typedef struct packed {
		logic [BURST_MAX-1:0][7:0] bytes;
		logic [BURST_IDX_W-1:0]    last_idx;
		logic                      ends_frame;
	} smf_burst_t;

endpackage
`default_nettype wire

// ----- hw/rtl/spi_message_framer_with_checksum_top.sv -----
// Top level of the SPI message framer with sum checksum.
// Instantiates smf_regs, smf_frame_ctl and smf_out_stage; depends on smf_pkg.
`default_nettype none
// The framer takes one item per transaction on the item channel and sends the
// framed message one byte per transaction on the result channel. A start item
// yields the control pipe byte, three zero fill bytes, the message id and the
// length (one byte below 255, else 255 then high and low bytes), and for an
// empty payload the checksum right after; that is six to eight bytes. Each
// payload byte of an open frame is passed on, and the last one is followed by
// the checksum, which carries frame_last. Payload items outside a frame and all
// items while framer_enable is zero produce nothing. The frame state is updated
// in the cycle an item is accepted, and each item's bytes are kept as one burst
// in a burst register ahead of the output serializer. Rate: an item whose
// burst is one byte passes at one item per cycle while the result side is
// ready; an item with several result bytes holds the serializer until its
// last byte is taken, so the serializer's single output port sets the pace.
// The burst register lets the next item be accepted while the current burst
// still drains. An item's bytes reach the output through the burst register
// and then the serializer. Registers sit at byte addresses 0 (framer_enable), 4
// (control_pipe_byte) and 8 (master_address); they should be written only
// while the block is idle, and master_address is sampled on each start item.
module spi_message_framer_with_checksum_top
	import smf_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  item_valid,
	output logic                       item_ready,
	input  wire smf_in_t               item,
	output logic                       result_valid,
	input  wire logic                  result_ready,
	output smf_out_t                   result,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [REG_ADDR_W-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output logic                       pready
);

	smf_cfg_t   cfg;
	smf_burst_t burst;
	logic       burst_valid;
	logic       accept;

	// An item transaction completes when both sides agree in the same cycle.
	assign accept = item_valid && item_ready;

	smf_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Frame state lives here; it turns the accepted item into a burst of bytes.
	smf_frame_ctl u_frame_ctl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.accept      (accept),
		.item        (item),
		.burst       (burst),
		.burst_valid (burst_valid)
	);

	// Burst register plus serializer; it also decides when the next item may enter.
	smf_out_stage u_out_stage (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.burst        (burst),
		.burst_valid  (burst_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
`default_nettype wire

// ----- hw/rtl/smf_regs.sv -----
// Configuration register file of the SPI message framer, on an APB-style port.
// Depends on smf_pkg for the configuration struct and register indexes.
`default_nettype none
module smf_regs
	import smf_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [REG_ADDR_W-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output logic                       pready,
	output smf_cfg_t                   cfg
);

	smf_cfg_t cfg_q;
	logic     wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.framer_enable     <= 1'b1;
			cfg_q.control_pipe_byte <= 8'd3;
			cfg_q.master_address    <= 8'hFF;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_ENABLE:    cfg_q.framer_enable     <= pwdata[0];
				REG_PIPE_BYTE: cfg_q.control_pipe_byte <= pwdata[7:0];
				REG_MASTER:    cfg_q.master_address    <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = 32'd0;
		unique case (paddr[3:2])
			REG_ENABLE:    prdata = {31'd0, cfg_q.framer_enable};
			REG_PIPE_BYTE: prdata = {24'd0, cfg_q.control_pipe_byte};
			REG_MASTER:    prdata = {24'd0, cfg_q.master_address};
			default:       prdata = 32'd0;
		endcase
	end

	// paddr[1:0] only selects bytes within a word and has no effect here.
	logic unused_addr;
	assign unused_addr = ^paddr[1:0];

endmodule
`default_nettype wire

// ----- hw/rtl/smf_frame_ctl.sv -----
// Frame state and burst builder of the SPI message framer.
// Turns one accepted item into its burst of result bytes and updates the frame state.
// Depends on smf_pkg.
`default_nettype none
module smf_frame_ctl
	import smf_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire smf_cfg_t cfg,
	input  wire logic     accept,
	input  wire smf_in_t  item,
	output smf_burst_t    burst,
	output logic          burst_valid
);

	logic        frame_open_q;
	logic [15:0] bytes_remaining_q;
	logic [7:0]  running_checksum_q;

	logic        nxt_open;
	logic [15:0] nxt_remaining;
	logic [7:0]  nxt_checksum;

	logic [7:0]  hdr_sum;
	logic        len_short;
	logic        len_zero;

	assign len_short = item.payload_length < {8'd0, EXT_LEN_MARK};
	assign len_zero  = item.payload_length == 16'd0;
	assign hdr_sum   = 8'd0 - cfg.master_address - item.msg_id;

	always_comb begin
		burst         = '0;
		burst_valid   = 1'b0;
		nxt_open      = frame_open_q;
		nxt_remaining = bytes_remaining_q;
		nxt_checksum  = running_checksum_q;
		if (cfg.framer_enable) begin
			if (item.req_type == REQ_START) begin
				burst_valid    = 1'b1;
				burst.bytes[0] = cfg.control_pipe_byte;
				burst.bytes[4] = item.msg_id;
				if (len_short) begin
					nxt_checksum   = hdr_sum - item.payload_length[7:0];
					burst.bytes[5] = item.payload_length[7:0];
					burst.last_idx = BURST_IDX_W'(5);
				end else begin
					nxt_checksum   = hdr_sum - EXT_LEN_MARK - item.payload_length[15:8]
						- item.payload_length[7:0];
					burst.bytes[5] = EXT_LEN_MARK;
					burst.bytes[6] = item.payload_length[15:8];
					burst.bytes[7] = item.payload_length[7:0];
					burst.last_idx = BURST_IDX_W'(7);
				end
				if (len_zero) begin
					// An empty payload closes the frame with its checksum at once.
					burst.bytes[6]   = nxt_checksum;
					burst.last_idx   = BURST_IDX_W'(6);
					burst.ends_frame = 1'b1;
				end
				nxt_open      = !len_zero;
				nxt_remaining = item.payload_length;
			end else if (!frame_open_q || bytes_remaining_q == 16'd0) begin
				// A payload byte outside an open frame is dropped.
				nxt_open = 1'b0;
			end else begin
				burst_valid    = 1'b1;
				nxt_checksum   = running_checksum_q - item.payload_byte;
				nxt_remaining  = bytes_remaining_q - 16'd1;
				burst.bytes[0] = item.payload_byte;
				if (bytes_remaining_q == 16'd1) begin
					burst.bytes[1]   = nxt_checksum;
					burst.last_idx   = BURST_IDX_W'(1);
					burst.ends_frame = 1'b1;
					nxt_open         = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q       <= 1'b0;
			bytes_remaining_q  <= 16'd0;
			running_checksum_q <= 8'd0;
		end else if (accept) begin
			frame_open_q       <= nxt_open;
			bytes_remaining_q  <= nxt_remaining;
			running_checksum_q <= nxt_checksum;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/smf_out_stage.sv -----
// Burst register and output serializer of the SPI message framer.
// Holds one waiting burst and sends the current one a byte per transaction.
// Depends on smf_pkg.
`default_nettype none
module smf_out_stage
	import smf_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire smf_burst_t burst,
	input  wire logic       burst_valid,
	output logic            item_ready,
	output logic            result_valid,
	input  wire logic       result_ready,
	output smf_out_t        result
);

	smf_burst_t             burst_s1;
	logic                   valid_s1;
	smf_burst_t             burst_s2;
	logic                   valid_s2;
	logic [BURST_IDX_W-1:0] idx_q;

	logic at_last;
	logic s2_free;
	logic advance;

	assign at_last    = idx_q == burst_s2.last_idx;
	assign s2_free    = !valid_s2 || (result_ready && at_last);
	assign advance    = valid_s1 && s2_free;
	assign item_ready = !valid_s1 || s2_free;

	assign result_valid      = valid_s2;
	assign result.out_byte   = burst_s2.bytes[idx_q];
	assign result.frame_last = burst_s2.ends_frame && at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= burst_valid;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && burst_valid) begin
			burst_s1 <= burst;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= '0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
			idx_q    <= '0;
		end else if (result_ready) begin
			idx_q <= idx_q + BURST_IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			burst_s2 <= burst_s1;
		end
	end

`ifndef SYNTHESIS
	a_idx_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> idx_q <= burst_s2.last_idx)
		else $error("serializer index ran past the end of its burst");

	a_wait_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s2_free) |=> valid_s1)
		else $error("waiting burst lost while the serializer was busy");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> item_ready)
		else $error("item not taken although the burst register is empty");

	a_last_ends_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_ready && result.frame_last) |=> (idx_q == '0))
		else $error("frame end byte did not close its burst");
`endif

endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
// Self-checking testbench for spi_message_framer_with_checksum_top.
// Drives items and APB register writes, predicts the framed byte stream and checks each result.
// Depends on smf_pkg and the framer RTL.
module tb_top;
	import smf_pkg::*;

	localparam int ITEM_TARGET     = 270;
	localparam int PHASES          = 6;
	localparam int MAX_IDLE        = 11;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int SETTLE_CYCLES   = 10;
	localparam int DRAIN_LIMIT     = 4000;
	localparam int REPORT_LIMIT    = 10;
	localparam int NUM_DIR_ROWS    = 29;

	// Byte addresses of the registers; the spare one decodes to no register at all.
	localparam logic [REG_ADDR_W-1:0] ADDR_ENABLE = {REG_ENABLE, 2'b00};
	localparam logic [REG_ADDR_W-1:0] ADDR_PIPE   = {REG_PIPE_BYTE, 2'b00};
	localparam logic [REG_ADDR_W-1:0] ADDR_MASTER = {REG_MASTER, 2'b00};
	localparam logic [REG_ADDR_W-1:0] ADDR_SPARE  = 4'd12;

	// One row of the directed table. A row is either a register write or an item.
	// Item rows with use_fixed set carry their expected bytes typed in; the last
	// typed byte carries fixed_last. Other item rows rely on the predictor.
	typedef struct packed {
		logic                  is_cfg;
		logic [REG_ADDR_W-1:0] cfg_addr;
		logic [31:0]           cfg_data;
		smf_in_t               stim;
		logic                  use_fixed;
		logic [3:0]            n_fixed;
		logic [0:8][7:0]       fixed;
		logic                  fixed_last;
	} dir_row_t;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  item_valid   = 1'b0;
	logic                  item_ready;
	smf_in_t               item         = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	smf_out_t              result;
	logic                  psel         = 1'b0;
	logic                  penable      = 1'b0;
	logic                  pwrite       = 1'b0;
	logic [REG_ADDR_W-1:0] paddr        = '0;
	logic [31:0]           pwdata       = '0;
	logic [31:0]           prdata;
	logic                  pready;

	spi_message_framer_with_checksum_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #5 clk = ~clk;

	// Shadow copy of the registers, kept in step with every APB write.
	logic       shadow_enable = 1'b1;
	logic [7:0] shadow_pipe   = 8'd3;
	logic [7:0] shadow_master = 8'd255;

	// Framing state of the predictor.
	logic        frame_open_q = 1'b0;
	logic [15:0] bytes_left   = '0;
	logic [7:0]  check_sum    = '0;

	// Bytes the last accepted item causes, and all bytes still owed by the block.
	smf_out_t burst_bytes[$];
	smf_out_t expected_bytes[$];

	dir_row_t directed_rows [NUM_DIR_ROWS];

	// Idling control shared by the sender, the receiver and the main sequence.
	bit calm_send    = 1'b0;
	bit calm_recv    = 1'b0;
	bit hold_off_req = 1'b0;

	int fail_count       = 0;
	int items_accepted   = 0;
	int productive_items = 0;
	int results_checked  = 0;
	int frames_closed    = 0;

	function automatic void report(input string msg);
		fail_count++;
		if (fail_count <= REPORT_LIMIT) begin
			$display("%s", msg);
		end
	endfunction

	// Emits a byte that counts toward the checksum.
	function automatic void push_summed(input logic [7:0] b);
		check_sum = check_sum - b;
		burst_bytes.push_back(smf_out_t'{b, 1'b0});
	endfunction

	// Predicts the bytes one accepted item causes and advances the framing state.
	function automatic void frame_item(input smf_in_t it);
		burst_bytes.delete();
		if (!shadow_enable) begin
			return;
		end
		if (it.req_type == REQ_START) begin
			// A start always opens a fresh frame, abandoning any open one.
			burst_bytes.push_back(smf_out_t'{shadow_pipe, 1'b0});
			repeat (3) burst_bytes.push_back(smf_out_t'{8'h00, 1'b0});
			check_sum = 8'h00 - shadow_master;
			push_summed(it.msg_id);
			if (it.payload_length < EXT_LEN_MARK) begin
				push_summed(it.payload_length[7:0]);
			end else begin
				push_summed(EXT_LEN_MARK);
				push_summed(it.payload_length[15:8]);
				push_summed(it.payload_length[7:0]);
			end
			if (it.payload_length == 16'd0) begin
				burst_bytes.push_back(smf_out_t'{check_sum, 1'b1});
				frame_open_q = 1'b0;
				bytes_left = '0;
			end else begin
				frame_open_q = 1'b1;
				bytes_left = it.payload_length;
			end
		end else if (!frame_open_q || bytes_left == 16'd0) begin
			frame_open_q = 1'b0;
		end else begin
			push_summed(it.payload_byte);
			bytes_left = bytes_left - 16'd1;
			if (bytes_left == 16'd0) begin
				burst_bytes.push_back(smf_out_t'{check_sum, 1'b1});
				frame_open_q = 1'b0;
			end
		end
	endfunction

	function automatic dir_row_t row_start(input logic [7:0] id, input logic [15:0] len,
			input int n_fixed = -1, input logic [0:8][7:0] fixed = '0,
			input logic fixed_last = 1'b0);
		dir_row_t row;
		row = '0;
		row.stim.req_type = REQ_START;
		row.stim.msg_id = id;
		row.stim.payload_length = len;
		row.stim.payload_byte = 8'($urandom);
		row.use_fixed = (n_fixed >= 0);
		row.n_fixed = 4'(n_fixed);
		row.fixed = fixed;
		row.fixed_last = fixed_last;
		return row;
	endfunction

	function automatic dir_row_t row_pay(input logic [7:0] b, input int n_fixed = -1);
		dir_row_t row;
		row = '0;
		row.stim.req_type = REQ_PAYLOAD;
		row.stim.msg_id = 8'($urandom);
		row.stim.payload_length = 16'($urandom);
		row.stim.payload_byte = b;
		row.use_fixed = (n_fixed >= 0);
		row.n_fixed = 4'(n_fixed);
		return row;
	endfunction

	function automatic dir_row_t row_cfg(input logic [REG_ADDR_W-1:0] addr,
			input logic [31:0] data);
		dir_row_t row;
		row = '0;
		row.is_cfg = 1'b1;
		row.cfg_addr = addr;
		row.cfg_data = data;
		return row;
	endfunction

	// Offers one item, waits for its transaction and records what it should cause.
	// Valid stays high after the transaction so that a following item can go
	// back to back; whoever pauses next lowers it.
	task automatic send_item(input smf_in_t it, input bit use_fixed, input int n_fixed,
			input logic [0:8][7:0] fixed, input bit fixed_last, output int n_caused);
		int gap;
		gap = calm_send ? 0 : $urandom_range(0, MAX_IDLE);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (!item_ready);
		items_accepted++;
		frame_item(it);
		if (use_fixed) begin
			for (int i = 0; i < n_fixed; i++) begin
				expected_bytes.push_back(smf_out_t'{fixed[i],
					fixed_last && (i == n_fixed - 1)});
			end
			n_caused = n_fixed;
		end else begin
			foreach (burst_bytes[i]) expected_bytes.push_back(burst_bytes[i]);
			n_caused = burst_bytes.size();
		end
	endtask

	// Sends an item of the given kind with random content in every field it
	// does not need, and counts it if the block has to answer it.
	task automatic send_random(input logic kind, input logic [15:0] len);
		smf_in_t it;
		int n;
		it.req_type = kind;
		it.msg_id = 8'($urandom);
		it.payload_length = (kind == REQ_START) ? len : 16'($urandom);
		it.payload_byte = 8'($urandom);
		send_item(it, 1'b0, 0, '0, 1'b0, n);
		if (n > 0) begin
			productive_items++;
		end
	endtask

	// Lets the block run dry: no item offered, no byte owed, and a settling wait
	// for an item that causes no output but may still be in flight.
	task automatic wait_idle();
		item_valid <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write followed by a read of the same address. The shadow copy is
	// updated at the write's access edge, and the read must return it.
	task automatic cfg_write(input logic [REG_ADDR_W-1:0] addr, input logic [31:0] data);
		logic [31:0] want;
		logic known;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		known = 1'b1;
		want = '0;
		case (addr[3:2])
			REG_ENABLE: begin
				shadow_enable = data[0];
				want = {31'd0, shadow_enable};
			end
			REG_PIPE_BYTE: begin
				shadow_pipe = data[7:0];
				want = {24'd0, shadow_pipe};
			end
			REG_MASTER: begin
				shadow_master = data[7:0];
				want = {24'd0, shadow_master};
			end
			default: begin
				known = 1'b0;
			end
		endcase
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		if (known && prdata !== want) begin
			report($sformatf("register read at %0h: expected %08h, got %08h",
				addr, want, prdata));
		end
	endtask

	// Receiver. Before every result transaction it may insert a stall of random
	// length, and once on request it holds off for a long stretch so
	// that the block's buffering fills and the item channel backs up. Every
	// accepted result is compared field by field with the oldest expected byte.
	initial begin
		int stall;
		smf_out_t want;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				result_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end
			stall = calm_recv ? 0 : $urandom_range(0, MAX_IDLE);
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
			if (expected_bytes.size() == 0) begin
				report($sformatf("unexpected result: byte %02h last %0b",
					result.out_byte, result.frame_last));
			end else begin
				want = expected_bytes.pop_front();
				results_checked++;
				if (want.frame_last) begin
					frames_closed++;
				end
				if (result.out_byte !== want.out_byte ||
						result.frame_last !== want.frame_last) begin
					report($sformatf("result %0d: expected byte %02h last %0b, got byte %02h last %0b",
						results_checked, want.out_byte, want.frame_last,
						result.out_byte, result.frame_last));
				end
			end
		end
	end

	// Main sequence: reset, the directed table, then random phases with new
	// register settings between them, then the drain and the verdict.
	initial begin
		int n;
		int r;
		int k;
		int phase_end;
		int phase_budget;
		int waited;
		logic [15:0] len;
		dir_row_t row;

		// Directed table. The typed rows cover the reset settings, the length
		// extremes on either side of the extended-length marker and the empty
		// payload. The others cover a start inside an open frame, stray payload,
		// an address change while a frame is open, a disabled window that keeps
		// the frame open, and a write to an address with no register behind it.
		directed_rows = '{
			row_start(8'h00, 16'd0, 7,
				{8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00}, 1'b1),
			row_start(8'hFF, 16'd254, 6,
				{8'h03, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFE, 8'h00, 8'h00, 8'h00}),
			row_start(8'h12, 16'hFFFF, 8,
				{8'h03, 8'h00, 8'h00, 8'h00, 8'h12, 8'hFF, 8'hFF, 8'hFF, 8'h00}),
			row_start(8'hA5, 16'd255, 8,
				{8'h03, 8'h00, 8'h00, 8'h00, 8'hA5, 8'hFF, 8'h00, 8'hFF, 8'h00}),
			row_start(8'h5A, 16'd2),
			row_pay(8'h00),
			row_pay(8'hFF),
			row_pay(8'h77, 0),
			row_start(8'h01, 16'd1),
			row_pay(8'h80),
			row_cfg(ADDR_PIPE, 32'h0000_00FF),
			row_cfg(ADDR_MASTER, 32'h0000_0000),
			row_start(8'h00, 16'd0, 7,
				{8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1),
			row_start(8'h33, 16'd3),
			row_pay(8'h10),
			row_cfg(ADDR_MASTER, 32'h0000_0080),
			row_pay(8'h20),
			row_pay(8'h30),
			row_start(8'h44, 16'd2),
			row_pay(8'h01),
			row_cfg(ADDR_ENABLE, 32'h0000_0000),
			row_pay(8'h02, 0),
			row_start(8'h99, 16'd5, 0),
			row_cfg(ADDR_ENABLE, 32'h0000_0001),
			row_pay(8'h03),
			row_cfg(ADDR_SPARE, 32'hFFFF_FFFF),
			row_cfg(ADDR_PIPE, 32'h0000_0003),
			row_cfg(ADDR_MASTER, 32'h0000_00FF),
			row_start(8'h00, 16'd0, 7,
				{8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00}, 1'b1)
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.is_cfg) begin
				wait_idle();
				cfg_write(row.cfg_addr, row.cfg_data);
			end else begin
				send_item(row.stim, row.use_fixed, int'(row.n_fixed), row.fixed,
					row.fixed_last, n);
			end
		end

		// The items left over after the directed table are spread over the phases.
		phase_budget = (ITEM_TARGET - items_accepted) / PHASES;

		for (int phase_idx = 0; phase_idx < PHASES; phase_idx++) begin
			wait_idle();
			// Idling pattern of this phase: some phases run one side or both
			// without any gaps, the rest draw a gap before every transaction.
			calm_send = (phase_idx >= 1 && phase_idx <= 3);
			calm_recv = (phase_idx == 2 || phase_idx == 4);
			cfg_write(ADDR_ENABLE, 32'd1);
			case (phase_idx)
				1: begin
					cfg_write(ADDR_PIPE, 32'h0000_0000);
					cfg_write(ADDR_MASTER, 32'h0000_0000);
				end
				2: begin
					cfg_write(ADDR_PIPE, 32'h0000_00FF);
					cfg_write(ADDR_MASTER, 32'h0000_00FF);
				end
				default: begin
					cfg_write(ADDR_PIPE, {24'd0, 8'($urandom)});
					cfg_write(ADDR_MASTER, {24'd0, 8'($urandom)});
				end
			endcase

			// The long hold-off on the result side while items keep coming.
			if (phase_idx == 1) begin
				hold_off_req = 1'b1;
			end

			// A disabled window: everything offered here is swallowed.
			if (phase_idx == 2) begin
				cfg_write(ADDR_ENABLE, 32'd0);
				repeat (6) send_random(1'($urandom), 16'($urandom));
				wait_idle();
				cfg_write(ADDR_ENABLE, 32'd1);
			end

			phase_end = items_accepted + phase_budget;
			while (items_accepted < phase_end) begin
				r = $urandom_range(0, 99);
				if (r < 80) begin
					// Well-formed frame with random content, mostly short.
					k = $urandom_range(0, 99);
					if (k < 15) begin
						len = 16'd0;
					end else if (k < 80) begin
						len = 16'($urandom_range(1, 12));
					end else begin
						len = 16'($urandom_range(13, 40));
					end
					send_random(REQ_START, len);
					repeat (len) send_random(REQ_PAYLOAD, '0);
				end else if (r < 92) begin
					// Broken frame: cut short and left to the next start.
					len = ($urandom_range(0, 1) == 1) ? 16'($urandom)
						: 16'($urandom_range(2, 40));
					if (len < 16'd2) begin
						len = 16'd2;
					end
					k = $urandom_range(0, (len > 16'd8) ? 8 : int'(len) - 1);
					send_random(REQ_START, len);
					repeat (k) send_random(REQ_PAYLOAD, '0);
				end else begin
					// Noise: payload that is dropped unless a cut frame is open.
					repeat ($urandom_range(1, 3)) send_random(REQ_PAYLOAD, '0);
				end
			end
		end

		// Drain with the receiver always ready, then watch for stray output.
		item_valid <= 1'b0;
		calm_recv = 1'b1;
		waited = 0;
		while (expected_bytes.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (expected_bytes.size() != 0) begin
			report($sformatf("%0d expected result bytes never arrived",
				expected_bytes.size()));
		end
		repeat (2 * SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d items (%0d answered, %0d directed rows) in %0d phases.",
			items_accepted, productive_items, NUM_DIR_ROWS, PHASES);
		$display("Checked %0d result bytes and %0d closed frames across empty, short,",
			results_checked, frames_closed);
		$display("extended-header and abandoned frames, stray payload, a disabled window",);
		$display("and a long output stall.");
		if (fail_count == 0) begin
			$display("spi_message_framer_with_checksum_top test passed");
		end else begin
			$display("spi_message_framer_with_checksum_top test failed");
		end
		$finish;
	end

	// Watchdog, several times the slowest correct run.
	initial begin
		#4000000;
		$display("spi_message_framer_with_checksum_top test failed");
		$finish;
	end

endmodule
